/* hw/rtl/first_fit_range_allocator_defines.svh */
// Assertion macros shared by the range allocator RTL
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FFRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffra assertion failed");

// next-cycle implication, checked out of reset
`define FFRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffra assertion failed");

`endif

/* hw/rtl/ffra_pkg.sv */
// Shared widths, types and codes of the first-fit range allocator
package ffra_pkg;

    localparam int FUNC_W   = 1;
    localparam int COUNT_W  = 32;
    localparam int BASE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 33;
    localparam int USED_W   = 7;
    localparam int CAP_W    = 7;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FUNC_ALLOC = 1'b0;
    localparam t_func FUNC_FREE  = 1'b1;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NO_FIT = 2'd1;
    localparam t_status ST_FULL   = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

/* hw/rtl/ffra_req_if.sv */
// Request channel: operation, unit count and base of a freed range
interface ffra_req_if import ffra_pkg::*; ();
    logic               valid;
    logic               ready;
    t_func              func;
    logic [COUNT_W-1:0] unit_count;
    logic [BASE_W-1:0]  base_index;

    modport source (output valid, output func, output unit_count, output base_index,
                    input ready);
    modport sink   (input valid, input func, input unit_count, input base_index,
                    output ready);
endinterface

/* hw/rtl/ffra_rsp_if.sv */
// Result channel: status, granted base, free total and entry count
interface ffra_rsp_if import ffra_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [BASE_W-1:0]  alloc_base;
    logic [TOTAL_W-1:0] total_free;
    logic [USED_W-1:0]  entries_used;

    modport source (output valid, output status, output alloc_base, output total_free,
                    output entries_used, input ready);
    modport sink   (input valid, input status, input alloc_base, input total_free,
                    input entries_used, output ready);
endinterface

/* hw/rtl/ffra_cfg_if.sv */
// Configuration write channel carrying the capacity register value
interface ffra_cfg_if import ffra_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ffra_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hw/rtl/first_fit_range_allocator.sv */
// Top level of the first-fit range allocator with coalescing
//
// Usage: a request item on i_req carries func (allocate or free), unit_count
// and base_index. Each request yields exactly one result item on o_rsp:
// status, alloc_base, total_free and entries_used. The capacity register is
// written through i_cfg, which is always ready; write it only while idle.
// The free-range table lives in one RAM with a single write and a single
// registered read port; every step walks that port one entry per cycle.
// Steps per item, from accept to the next accept, with a hit at entry h:
//   allocate: scan up to h, then update; when the entry empties and is removed,
//   a shift walks the entries after h; a miss scans every entry in use
//   free: a search, then a shift where needed (the search stops where the shift starts, so the
//   two together cover the table once)
// One request is in flight at a time; i_req.ready is high only when idle,
// so the block takes no new request before it is through with the last one.
// A finished result sits in an output register; the next request is taken
// while it waits, and that request holds its result until o_rsp frees up.
// Reset (synchronous, active low) empties the table, clears the free total
// and sets capacity to 64; no clearing pass is needed.
`include "first_fit_range_allocator_defines.svh"

module first_fit_range_allocator import ffra_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int UNIT_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffra_req_if.sink   i_req,
    ffra_rsp_if.source o_rsp,
    ffra_cfg_if.sink   i_cfg
);

    localparam int SW = UNIT_BITS + 1;
    localparam int EW = UNIT_BITS + SW;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = SW + CW;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [SW-1:0] SIZE_MAX = '1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SCAN   = 5'd1;
    localparam logic [4:0] S_A_BASE = 5'd2;
    localparam logic [4:0] S_A_SIZE = 5'd3;
    localparam logic [4:0] S_A_TOT  = 5'd4;
    localparam logic [4:0] S_F_LCHK = 5'd5;
    localparam logic [4:0] S_F_RCHK = 5'd6;
    localparam logic [4:0] S_F_M1   = 5'd7;
    localparam logic [4:0] S_F_M2   = 5'd8;
    localparam logic [4:0] S_F_R1   = 5'd9;
    localparam logic [4:0] S_T_SL   = 5'd10;
    localparam logic [4:0] S_T_SR   = 5'd11;
    localparam logic [4:0] S_T_AN   = 5'd12;
    localparam logic [4:0] S_COMMIT = 5'd13;
    localparam logic [4:0] S_SHDN   = 5'd14;
    localparam logic [4:0] S_SHUP   = 5'd15;
    localparam logic [4:0] S_INSW   = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0]           r_state;
    t_func                r_func;
    logic [UNIT_BITS-1:0] r_cnt;
    logic [UNIT_BITS-1:0] r_idx;
    logic [CAP_W-1:0]     r_cap;
    logic [CW-1:0]        r_used;
    logic [TW-1:0]        r_total;
    logic [CW-1:0]        r_pos;
    logic                 r_dv;
    logic [UNIT_BITS-1:0] r_lb;
    logic [SW-1:0]        r_ls;
    logic [UNIT_BITS-1:0] r_rb;
    logic [SW-1:0]        r_rs;
    logic                 r_rv;
    logic                 r_lm;
    logic                 r_rm;
    logic                 r_do_wr;
    logic                 r_do_rm;
    logic                 r_do_ins;
    logic [UNIT_BITS-1:0] r_nb;
    logic [SW-1:0]        r_ns;
    logic [CW-1:0]        r_wa;
    logic [CW-1:0]        r_k;
    t_status              r_status;
    logic [UNIT_BITS-1:0] r_granted;
    logic                 r_ov;
    t_status              r_o_status;
    logic [BASE_W-1:0]    r_o_base;
    logic [TOTAL_W-1:0]   r_o_total;
    logic [USED_W-1:0]    r_o_used;

    // shared add/subtract unit
    logic [TW-1:0] u_a;
    logic [TW-1:0] u_b;
    logic          u_sub;
    logic [TW:0]   u_res;
    logic          u_borrow;
    logic [SW-1:0] u_sat;

    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [CW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [UNIT_BITS-1:0] cur_base;
    logic [SW-1:0]        cur_size;
    logic                 scan_hit;
    logic                 f_rm;
    logic                 ins_ok;
    logic [SW-1:0]        total_sat;

    assign cur_base = ram_rdata[EW-1:SW];
    assign cur_size = ram_rdata[SW-1:0];

    always_comb begin
        u_a       = '0;
        u_b       = '0;
        u_sub     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = {r_nb, r_ns};
        ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
            end
            S_SCAN: begin
                // allocate: size >= count; free: base > index shows as a borrow
                if (r_func == FUNC_ALLOC) begin
                    u_a = TW'(cur_size);
                    u_b = TW'(r_cnt);
                end else begin
                    u_a = TW'(r_idx);
                    u_b = TW'(cur_base);
                end
                u_sub     = 1'b1;
                ram_raddr = r_pos + CW'(1);
            end
            S_A_BASE: begin
                u_a = TW'(r_rb);
                u_b = TW'(r_cnt);
            end
            S_A_SIZE: begin
                u_a   = TW'(r_rs);
                u_b   = TW'(r_cnt);
                u_sub = 1'b1;
            end
            S_A_TOT: begin
                u_a   = r_total;
                u_b   = TW'(r_cnt);
                u_sub = 1'b1;
            end
            S_F_LCHK: begin
                u_a   = TW'(r_idx);
                u_b   = TW'(r_lb);
                u_sub = 1'b1;
            end
            S_F_RCHK: begin
                u_a   = TW'(r_rb);
                u_b   = TW'(r_idx);
                u_sub = 1'b1;
            end
            S_F_M1: begin
                u_a = TW'(r_ls);
                u_b = TW'(r_cnt);
            end
            S_F_M2: begin
                u_a = TW'(r_ns);
                u_b = TW'(r_rs);
            end
            S_F_R1: begin
                u_a = TW'(r_rs);
                u_b = TW'(r_cnt);
            end
            S_T_SL: begin
                u_a   = r_total;
                u_b   = TW'(r_ls);
                u_sub = 1'b1;
            end
            S_T_SR: begin
                u_a   = r_total;
                u_b   = TW'(r_rs);
                u_sub = 1'b1;
            end
            S_T_AN: begin
                u_a = r_total;
                u_b = TW'(r_ns);
            end
            S_COMMIT: begin
                if (r_do_ins) begin
                    ram_raddr = r_used - CW'(1);
                end else begin
                    ram_we    = r_do_wr;
                    ram_raddr = r_pos + CW'(1);
                end
            end
            S_SHDN: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = ram_rdata;
                ram_raddr = r_k + CW'(2);
            end
            S_SHUP: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = ram_rdata;
                ram_raddr = r_k - CW'(2);
            end
            S_INSW: begin
                ram_we = 1'b1;
            end
            S_OUT: begin
                ram_raddr = '0;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
        u_res = u_sub ? ({1'b0, u_a} - {1'b0, u_b}) : ({1'b0, u_a} + {1'b0, u_b});
    end

    assign u_borrow  = u_res[TW];
    assign u_sat     = (|u_res[TW:SW]) ? SIZE_MAX : u_res[SW-1:0];
    assign scan_hit  = u_borrow ^ (r_func == FUNC_ALLOC);
    assign f_rm      = r_rv && !u_borrow && (u_res[TW-1:0] == TW'(r_cnt));
    assign ins_ok    = (LW'(r_used) < LW'(r_cap)) && (LW'(r_used) < LW'(TABLE_DEPTH));
    assign total_sat = (|r_total[TW-1:SW]) ? SIZE_MAX : r_total[SW-1:0];

    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
            r_cap   <= CAP_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
            // S_OUT handles the output register itself
            if (r_ov && o_rsp.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func    <= i_req.func;
                        r_cnt     <= UNIT_BITS'(i_req.unit_count);
                        r_idx     <= UNIT_BITS'(i_req.base_index);
                        r_pos     <= '0;
                        r_dv      <= (r_used != '0);
                        r_rv      <= 1'b0;
                        r_lm      <= 1'b0;
                        r_rm      <= 1'b0;
                        r_do_wr   <= 1'b0;
                        r_do_rm   <= 1'b0;
                        r_do_ins  <= 1'b0;
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_dv) begin
                        // ran past the last entry in use
                        if (r_func == FUNC_ALLOC) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_F_LCHK;
                        end
                    end else if (scan_hit) begin
                        r_rb    <= cur_base;
                        r_rs    <= cur_size;
                        r_rv    <= 1'b1;
                        r_state <= (r_func == FUNC_ALLOC) ? S_A_BASE : S_F_LCHK;
                    end else begin
                        r_lb  <= cur_base;
                        r_ls  <= cur_size;
                        r_pos <= r_pos + CW'(1);
                        r_dv  <= ((r_pos + CW'(1)) < r_used);
                    end
                end
                S_A_BASE: begin
                    r_nb      <= u_res[UNIT_BITS-1:0];
                    r_granted <= r_rb;
                    r_state   <= S_A_SIZE;
                end
                S_A_SIZE: begin
                    r_ns    <= u_res[SW-1:0];
                    r_wa    <= r_pos;
                    r_state <= S_A_TOT;
                end
                S_A_TOT: begin
                    r_total <= u_res[TW-1:0];
                    r_do_wr <= (r_ns != '0);
                    r_do_rm <= (r_ns == '0);
                    r_state <= S_COMMIT;
                end
                S_F_LCHK: begin
                    // left neighbor ends exactly at the freed base
                    r_lm    <= (r_pos != '0) && !u_borrow
                               && (u_res[TW-1:0] == TW'(r_ls));
                    r_state <= S_F_RCHK;
                end
                S_F_RCHK: begin
                    r_rm <= f_rm;
                    if (r_lm) begin
                        r_state <= S_F_M1;
                    end else if (f_rm) begin
                        r_state <= S_F_R1;
                    end else if (ins_ok) begin
                        r_nb     <= r_idx;
                        r_ns     <= SW'(r_cnt);
                        r_wa     <= r_pos;
                        r_do_ins <= 1'b1;
                        r_state  <= S_T_AN;
                    end else begin
                        r_status <= ST_FULL;
                        r_state  <= S_OUT;
                    end
                end
                S_F_M1: begin
                    r_ns    <= u_sat;
                    r_nb    <= r_lb;
                    r_wa    <= r_pos - CW'(1);
                    r_do_wr <= 1'b1;
                    r_do_rm <= r_rm;
                    r_state <= r_rm ? S_F_M2 : S_T_SL;
                end
                S_F_M2: begin
                    r_ns    <= u_sat;
                    r_state <= S_T_SL;
                end
                S_F_R1: begin
                    r_ns    <= u_sat;
                    r_nb    <= r_idx;
                    r_wa    <= r_pos;
                    r_do_wr <= 1'b1;
                    r_state <= S_T_SR;
                end
                S_T_SL: begin
                    r_total <= u_res[TW-1:0];
                    r_state <= r_rm ? S_T_SR : S_T_AN;
                end
                S_T_SR: begin
                    r_total <= u_res[TW-1:0];
                    r_state <= S_T_AN;
                end
                S_T_AN: begin
                    r_total <= u_res[TW-1:0];
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (r_do_ins) begin
                        r_k     <= r_used;
                        r_state <= (r_used > r_pos) ? S_SHUP : S_INSW;
                    end else if (r_do_rm) begin
                        if ((r_pos + CW'(1)) < r_used) begin
                            r_k     <= r_pos;
                            r_state <= S_SHDN;
                        end else begin
                            r_used  <= r_used - CW'(1);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SHDN: begin
                    if ((r_k + CW'(2)) < r_used) begin
                        r_k <= r_k + CW'(1);
                    end else begin
                        r_used  <= r_used - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_SHUP: begin
                    if (r_k > (r_pos + CW'(1))) begin
                        r_k <= r_k - CW'(1);
                    end else begin
                        r_state <= S_INSW;
                    end
                end
                S_INSW: begin
                    r_used  <= r_used + CW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_base   <= BASE_W'(r_granted);
                        r_o_total  <= TOTAL_W'(total_sat);
                        r_o_used   <= USED_W'(r_used);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.alloc_base   = r_o_base;
    assign o_rsp.total_free   = r_o_total;
    assign o_rsp.entries_used = r_o_used;

    `FFRA_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, r_state == S_IDLE, r_used <= CW'(TABLE_DEPTH))
    `FFRA_ASSERT_IMP(a_scan_pos, i_clk, i_rst_n, r_state == S_SCAN, r_pos <= r_used)
    `FFRA_ASSERT_IMP(a_ins_room, i_clk, i_rst_n, r_state == S_INSW, r_used < CW'(TABLE_DEPTH))
    `FFRA_ASSERT_IMP(a_base_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.alloc_base == '0)
    `FFRA_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)

endmodule

/* test/first_fit_range_allocator_tb.sv */
// Self-checking testbench for the first-fit range allocator: directed table, then random phases
module first_fit_range_allocator_tb import ffra_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int PHASE_ITEMS  = 228;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 200;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        t_status            status;
        logic [BASE_W-1:0]  alloc_base;
        logic [TOTAL_W-1:0] total_free;
        logic [USED_W-1:0]  entries_used;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CAP} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_func              func;
        logic [COUNT_W-1:0] count;    // capacity value on a ROW_CAP row
        logic [BASE_W-1:0]  base;
        logic               typed;
        t_result            want;
    } t_row;

    typedef struct {
        logic [BASE_W-1:0]  base;
        logic [COUNT_W-1:0] count;
    } t_chunk;

    localparam t_result NO_WANT = '0;

    t_row dir_rows [25] = '{
        '{ROW_ITEM, FUNC_ALLOC, 32'd0,         32'd0,         1'b1, '{ST_NO_FIT, 0, 0, 0}},
        '{ROW_ITEM, FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_NO_FIT, 0, 0, 0}},
        '{ROW_ITEM, FUNC_FREE,  32'd100,       32'd1000,      1'b1, '{ST_OK, 0, 100, 1}},
        '{ROW_ITEM, FUNC_FREE,  32'd50,        32'd1100,      1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd10,        32'd990,       1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd20,        32'd2000,      1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd850,       32'd1150,      1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd0,         32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd30,        32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd1000,      32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd0,         32'd5,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd0,         32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'hFFFF_FFFF, 32'd0,         1'b1,
          '{ST_OK, 0, 33'h0_FFFF_FFFF, 1}},
        '{ROW_ITEM, FUNC_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd5,         32'hFFFF_FFFF, 1'b1,
          '{ST_OK, 0, 33'h1_FFFF_FFFF, 2}},
        '{ROW_ITEM, FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd6,         32'd0,         1'b1, '{ST_NO_FIT, 0, 5, 1}},
        '{ROW_ITEM, FUNC_FREE,  32'd5,         32'hFFFF_FFFA, 1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd1,         32'd4,         1'b0, NO_WANT},
        '{ROW_CAP,  FUNC_ALLOC, 32'd0,         32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_FREE,  32'd7,         32'd100,       1'b1, '{ST_FULL, 0, 11, 2}},
        '{ROW_ITEM, FUNC_FREE,  32'd1,         32'd5,         1'b0, NO_WANT},
        '{ROW_CAP,  FUNC_ALLOC, 32'd127,       32'd0,         1'b0, NO_WANT},
        '{ROW_ITEM, FUNC_ALLOC, 32'd2,         32'd0,         1'b0, NO_WANT}
    };

    logic [CAP_W-1:0] phase_caps [8] = '{7'd127, 7'd1, 7'd0, 7'd3, 7'd64, 7'd2, 7'd40, 7'd64};

    logic clk;
    logic rst_n;

    ffra_req_if req_if ();
    ffra_rsp_if rsp_if ();
    ffra_cfg_if cfg_if ();

    first_fit_range_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // free-range table as the block should hold it, sorted by base
    logic [BASE_W-1:0]  free_base [DEPTH];
    logic [TOTAL_W-1:0] free_size [DEPTH];
    int                 free_entries;
    logic [CAP_W-1:0]   capacity;

    t_result            due_results [$];
    t_chunk             held_chunks [$];
    logic [BASE_W-1:0]  fresh_cursor;
    bit                 req_calm;
    int                 mismatches;

    function automatic logic [TOTAL_W-1:0] size_sum(logic [TOTAL_W-1:0] a,
                                                    logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = a + b;
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    // no wrap: the range must end exactly at p
    function automatic bit ends_at(longint unsigned b, longint unsigned s, longint unsigned p);
        return p >= b && (p - b) == s;
    endfunction

    function automatic void drop_entry(int i);
        int k;
        free_entries--;
        for (k = i; k < free_entries; k++) begin
            free_base[k] = free_base[k+1];
            free_size[k] = free_size[k+1];
        end
    endfunction

    function automatic t_result apply_request(t_func func, logic [COUNT_W-1:0] cnt,
                                              logic [BASE_W-1:0] idx);
        t_result r;
        int      i;
        int      j;
        int      limit;
        bit      done;
        r = '0;
        r.status = ST_OK;
        limit = (capacity < DEPTH) ? int'(capacity) : DEPTH;
        if (func == FUNC_ALLOC) begin
            r.status = ST_NO_FIT;
            for (i = 0; i < free_entries; i++) begin
                if (free_size[i] >= cnt) begin
                    r.status     = ST_OK;
                    r.alloc_base = free_base[i];
                    free_base[i] = free_base[i] + cnt;
                    free_size[i] = free_size[i] - cnt;
                    if (free_size[i] == 0) drop_entry(i);
                    break;
                end
            end
        end else begin
            done = 1'b0;
            for (i = 0; i < free_entries; i++) begin
                if (free_base[i] > idx) break;
            end
            if (i > 0 && ends_at(free_base[i-1], free_size[i-1], idx)) begin
                free_size[i-1] = size_sum(free_size[i-1], cnt);
                if (i < free_entries && ends_at(idx, cnt, free_base[i])) begin
                    free_size[i-1] = size_sum(free_size[i-1], free_size[i]);
                    drop_entry(i);
                end
                done = 1'b1;
            end
            if (!done && i < free_entries && ends_at(idx, cnt, free_base[i])) begin
                free_base[i] = idx;
                free_size[i] = size_sum(free_size[i], cnt);
                done = 1'b1;
            end
            if (!done) begin
                if (free_entries < limit) begin
                    for (j = free_entries; j > i; j--) begin
                        free_base[j] = free_base[j-1];
                        free_size[j] = free_size[j-1];
                    end
                    free_base[i] = idx;
                    free_size[i] = cnt;
                    free_entries++;
                end else begin
                    r.status = ST_FULL;
                end
            end
        end
        r.total_free = '0;
        for (i = 0; i < free_entries; i++) r.total_free = size_sum(r.total_free, free_size[i]);
        r.entries_used = USED_W'(free_entries);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) $display("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    task automatic send_request(t_func func, logic [COUNT_W-1:0] cnt, logic [BASE_W-1:0] idx,
                                bit typed, t_result want);
        int      gap;
        t_result got;
        if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
        gap = req_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.unit_count <= cnt;
        req_if.base_index <= idx;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        got = apply_request(func, cnt, idx);
        due_results.push_back(typed ? want : got);
        if (func == FUNC_ALLOC && got.status == ST_OK && cnt != 0)
            held_chunks.push_back('{got.alloc_base, cnt});
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain();
        req_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        capacity = value;
    endtask

    task automatic random_request();
        int                 pick;
        int                 k;
        logic [COUNT_W-1:0] cnt;
        logic [BASE_W-1:0]  idx;
        t_func              func;
        t_chunk             c;
        pick = $urandom_range(0, 99);
        if (pick >= 40 && pick < 75 && held_chunks.size() == 0) pick = 80;
        if (pick < 40) begin
            func = FUNC_ALLOC;
            idx  = $urandom;
            case ($urandom_range(0, 15))
                0:       cnt = '0;
                1:       cnt = $urandom_range(1, 65535);
                default: cnt = $urandom_range(1, 256);
            endcase
        end else if (pick < 75) begin
            // give back something granted earlier, so neighbors coalesce
            func = FUNC_FREE;
            k    = $urandom_range(0, held_chunks.size() - 1);
            c    = held_chunks[k];
            held_chunks.delete(k);
            cnt  = c.count;
            idx  = c.base;
        end else if (pick < 88) begin
            // fresh region, a third of the time butting onto the previous one
            func = FUNC_FREE;
            cnt  = $urandom_range(16, 4096);
            if ($urandom_range(0, 2) != 0) fresh_cursor += $urandom_range(1, 1 << 20);
            idx  = fresh_cursor;
            fresh_cursor += cnt;
        end else begin
            func = t_func'($urandom_range(0, 1));
            idx  = $urandom;
            case ($urandom_range(0, 3))
                0:       cnt = '1;
                1:       cnt = '0;
                default: cnt = $urandom;
            endcase
        end
        send_request(func, cnt, idx, 1'b0, NO_WANT);
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin : stimulus
        int n;
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= FUNC_ALLOC;
        req_if.unit_count <= '0;
        req_if.base_index <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        capacity     = CAP_RESET;
        free_entries = 0;
        mismatches   = 0;
        req_calm     = 1'b0;
        fresh_cursor = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CAP)
                write_capacity(dir_rows[k].count[CAP_W-1:0]);
            else
                send_request(dir_rows[k].func, dir_rows[k].count, dir_rows[k].base,
                             dir_rows[k].typed, dir_rows[k].want);
        end

        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            fresh_cursor = $urandom;
            for (n = 0; n < PHASE_ITEMS; n++) random_request();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("first_fit_range_allocator: match");
        else
            $display("first_fit_range_allocator: mismatch");
        $finish;
    end

    initial begin : result_side
        int      gap;
        int      taken;
        bit      calm;
        t_result want;
        taken = 0;
        calm  = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 3);
            // one long hold-off so the block backs up into its input
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
            taken++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with nothing outstanding: status %0h total %0h",
                             rsp_if.status, rsp_if.total_free);
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, rsp_if.status);
                check_field("alloc_base", want.alloc_base, rsp_if.alloc_base);
                check_field("total_free", want.total_free, rsp_if.total_free);
                check_field("entries_used", want.entries_used, rsp_if.entries_used);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("first_fit_range_allocator: mismatch");
        $finish;
    end

endmodule
